### hw/rtl/pba_pkg.sv
// Shared constants and types for the page bitmap allocator.
`default_nettype none

package pba_pkg;

    localparam int PAGE_W         = 16;
    localparam int WORD_W         = 64;
    localparam int BIT_IDX_W      = 6;
    localparam int WORD_IDX_W     = PAGE_W - BIT_IDX_W;
    localparam int MAX_SCAN_WORDS = 1 << WORD_IDX_W;

    localparam logic [WORD_W-1:0] FULL_WORD = {WORD_W{1'b1}};

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_RESERVE = 2'd2;

    typedef struct packed {
        logic                 hit;
        logic [BIT_IDX_W-1:0] idx;
    } t_ffz;

endpackage

`default_nettype wire

### hw/rtl/pba_mem.sv
// Bitmap word store: one write port, one read port with registered read data.
`default_nettype none

module pba_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ADDR_W-1:0]          i_waddr,
    input  wire logic [pba_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [ADDR_W-1:0]          i_raddr,
    output logic      [pba_pkg::WORD_W-1:0] o_rdata
);

    logic [pba_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [pba_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/pba_ffz.sv
// Find-first-zero unit: lowest clear bit of one bitmap word.
`default_nettype none

module pba_ffz (
    input  wire logic [pba_pkg::WORD_W-1:0] i_word,
    output pba_pkg::t_ffz                   o_ffz
);

    always_comb begin
        o_ffz.hit = 1'b0;
        o_ffz.idx = '0;
        for (int b = pba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_ffz.hit = 1'b1;
                o_ffz.idx = pba_pkg::BIT_IDX_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/page_bitmap_allocator.sv
// Page bitmap allocator top level: sequencer around the word store and find-first-zero unit.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_ready   i_mode, i_page_number
//   out      from block o_out_valid / i_out_ready o_result_page, o_found
//
// Allocate: scans words from index 0 up to the first word with a free page, then sets
// that page's bit; the word store delivers one word per cycle to the scan.
// Free / reserve: read, modify-write, result.
// After reset a fill pass writes all-ones to min(BITMAP_WORDS,1024) words, one per
// cycle; no beat is accepted until it ends.
// A stalled output holds the finished result; the next result waits in the done step.
`default_nettype none

module page_bitmap_allocator #(
    parameter int BITMAP_WORDS = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [pba_pkg::PAGE_W-1:0] i_page_number,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [pba_pkg::PAGE_W-1:0] o_result_page,
    output logic                            o_found
);

    // only words whose pages fit in 16 bits are ever touched
    localparam int DEPTH = (BITMAP_WORDS < pba_pkg::MAX_SCAN_WORDS) ?
                           BITMAP_WORDS : pba_pkg::MAX_SCAN_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                          r_state, n_state;
    logic [ADDR_W-1:0]                   r_ptr, n_ptr;
    logic [ADDR_W-1:0]                   r_chk_ptr, n_chk_ptr;
    logic                                r_dv, n_dv;
    logic                                r_o_valid, n_o_valid;
    logic [ADDR_W-1:0]                   r_word_idx, n_word_idx;
    logic [pba_pkg::BIT_IDX_W-1:0]       r_bit, n_bit;
    logic                                r_rmw_set, n_rmw_set;
    logic [pba_pkg::PAGE_W-1:0]          r_res_page, n_res_page;
    logic                                r_res_found, n_res_found;
    logic [pba_pkg::PAGE_W-1:0]          r_o_page, n_o_page;
    logic                                r_o_found, n_o_found;

    logic                                mem_we;
    logic [ADDR_W-1:0]                   mem_waddr;
    logic [pba_pkg::WORD_W-1:0]          mem_wdata;
    logic                                mem_re;
    logic [ADDR_W-1:0]                   mem_raddr;
    logic [pba_pkg::WORD_W-1:0]          mem_rdata;

    logic [pba_pkg::WORD_W-1:0]          scan_word;
    pba_pkg::t_ffz                       ffz;
    logic                                accept;
    logic [pba_pkg::WORD_IDX_W-1:0]      in_word;
    logic                                in_range;
    logic                                out_free;

    pba_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // page 0 counts as used during the scan
    assign scan_word = mem_rdata |
                       ((r_chk_ptr == '0) ? pba_pkg::WORD_W'(1) : '0);

    pba_ffz u_ffz (
        .i_word (scan_word),
        .o_ffz  (ffz)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_word    = i_page_number[pba_pkg::PAGE_W-1:pba_pkg::BIT_IDX_W];
    assign in_range   = (32'(in_word) < DEPTH);
    assign out_free   = !r_o_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_chk_ptr   = r_chk_ptr;
        n_dv        = 1'b0;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_word_idx  = r_word_idx;
        n_bit       = r_bit;
        n_rmw_set   = r_rmw_set;
        n_res_page  = r_res_page;
        n_res_found = r_res_found;
        n_o_page    = r_o_page;
        n_o_found   = r_o_found;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = pba_pkg::FULL_WORD;
        mem_re      = 1'b0;
        mem_raddr   = r_ptr;

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_ptr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_page  = '0;
                    n_res_found = 1'b0;
                    n_ptr       = '0;
                    n_word_idx  = ADDR_W'(in_word);
                    n_bit       = i_page_number[pba_pkg::BIT_IDX_W-1:0];
                    n_rmw_set   = (i_mode == pba_pkg::MODE_RESERVE);
                    case (i_mode)
                        pba_pkg::MODE_ALLOC: begin
                            n_state = S_SCAN;
                        end
                        pba_pkg::MODE_FREE: begin
                            n_state = (in_range && i_page_number != '0) ? S_RD : S_DONE;
                        end
                        pba_pkg::MODE_RESERVE: begin
                            n_state = in_range ? S_RD : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read word r_ptr while checking the word read last cycle
                mem_re    = 1'b1;
                n_dv      = 1'b1;
                n_chk_ptr = r_ptr;
                if (r_ptr != LAST) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_dv) begin
                    if (ffz.hit) begin
                        mem_we      = 1'b1;
                        mem_waddr   = r_chk_ptr;
                        mem_wdata   = mem_rdata | (pba_pkg::WORD_W'(1) << ffz.idx);
                        n_res_page  = {pba_pkg::WORD_IDX_W'(r_chk_ptr), ffz.idx};
                        n_res_found = 1'b1;
                        n_dv        = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_chk_ptr == LAST) begin
                        n_dv    = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_word_idx;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_word_idx;
                mem_wdata = r_rmw_set ? (mem_rdata | (pba_pkg::WORD_W'(1) << r_bit))
                                      : (mem_rdata & ~(pba_pkg::WORD_W'(1) << r_bit));
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_page  = r_res_page;
                    n_o_found = r_res_found;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_ptr   <= n_chk_ptr;
        r_word_idx  <= n_word_idx;
        r_bit       <= n_bit;
        r_rmw_set   <= n_rmw_set;
        r_res_page  <= n_res_page;
        r_res_found <= n_res_found;
        r_o_page    <= n_o_page;
        r_o_found   <= n_o_found;
    end

    assign o_out_valid   = r_o_valid;
    assign o_result_page = r_o_page;
    assign o_found       = r_o_found;

`ifndef SYNTHESIS
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_result_page != '0)
        else $error("found result carries page 0");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_result_page == '0)
        else $error("miss result carries a page number");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while one is in progress");

    a_hit_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_dv && ffz.hit |=> r_state == S_DONE && r_res_found)
        else $error("scan did not stop on a free page");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench for the page bitmap allocator: directed table, then random traffic checked by a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS    = 1024;
    localparam int SCAN_WORDS   = (MAP_WORDS < pba_pkg::MAX_SCAN_WORDS) ?
                                  MAP_WORDS : pba_pkg::MAX_SCAN_WORDS;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 20000;
    localparam int PRINT_CAP    = 100;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [pba_pkg::PAGE_W-1:0] page;
        logic                       found;
    } t_grant;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [pba_pkg::PAGE_W-1:0] page;
        logic                       typed;
        logic [pba_pkg::PAGE_W-1:0] want_page;
        logic                       want_found;
    } t_row;

    typedef struct packed {
        logic   typed;
        t_grant want;
    } t_note;

    // typed = 1: expected grant written here; typed = 0: taken from the predictor
    localparam int N_ROWS = 26;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd0,    1'b0},  // everything used after reset
        '{pba_pkg::MODE_FREE,    16'd0,    1'b1, 16'd0,    1'b0},  // freeing page zero is ignored
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'hFFFF, 1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'hFFFF, 1'b1},  // full scan to the top page
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd1,    1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd63,   1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd64,   1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_ALLOC,   16'hFFFF, 1'b1, 16'd1,    1'b1},  // page field ignored on allocate
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd63,   1'b1},
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd64,   1'b1},
        '{pba_pkg::MODE_RESERVE, 16'd0,    1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd100,  1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_RESERVE, 16'd100,  1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd5,    1'b1, 16'd0,    1'b0},
        '{MODE_UNUSED,           16'd5,    1'b1, 16'd0,    1'b0},  // unused mode leaves the map alone
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b1, 16'd5,    1'b1},
        '{pba_pkg::MODE_FREE,    16'hAAAA, 1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'h5555, 1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd2,    1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_FREE,    16'd3,    1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_RESERVE, 16'd2,    1'b0, 16'd0,    1'b0},
        '{pba_pkg::MODE_ALLOC,   16'd0,    1'b0, 16'd0,    1'b0}
    };

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic [1:0]                 i_mode        = pba_pkg::MODE_ALLOC;
    logic [pba_pkg::PAGE_W-1:0] i_page_number = '0;
    logic                       i_out_ready   = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [pba_pkg::PAGE_W-1:0] o_result_page;
    logic                       o_found;

    logic [pba_pkg::WORD_W-1:0] page_map [MAP_WORDS];
    t_grant                     expected_grants [$];
    t_note                      req_notes [$];
    int                         mismatches  = 0;
    int                         idle_cycles = 0;
    bit                         quiet_in    = 1'b0;

    page_bitmap_allocator #(
        .BITMAP_WORDS(MAP_WORDS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_page_number(i_page_number),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_page(o_result_page),
        .o_found      (o_found)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one request to the shadow bitmap and returns the grant it yields.
    function automatic t_grant predict_grant(input logic [1:0] mode,
                                             input logic [pba_pkg::PAGE_W-1:0] page);
        t_grant g;
        bit     done;
        g    = '0;
        done = 1'b0;
        case (mode)
            pba_pkg::MODE_ALLOC: begin
                for (int w = 0; w < SCAN_WORDS && !done; w++) begin
                    if (page_map[w] != pba_pkg::FULL_WORD) begin
                        for (int b = 0; b < pba_pkg::WORD_W && !done; b++) begin
                            if (!(w == 0 && b == 0) && !page_map[w][b]) begin
                                page_map[w][b] = 1'b1;
                                g.page  = pba_pkg::PAGE_W'(w * pba_pkg::WORD_W + b);
                                g.found = 1'b1;
                                done    = 1'b1;
                            end
                        end
                    end
                end
            end
            pba_pkg::MODE_FREE: begin
                if (page != 0 &&
                    int'(page[pba_pkg::PAGE_W-1:pba_pkg::BIT_IDX_W]) < MAP_WORDS)
                    page_map[page[pba_pkg::PAGE_W-1:pba_pkg::BIT_IDX_W]]
                            [page[pba_pkg::BIT_IDX_W-1:0]] = 1'b0;
            end
            pba_pkg::MODE_RESERVE: begin
                if (int'(page[pba_pkg::PAGE_W-1:pba_pkg::BIT_IDX_W]) < MAP_WORDS)
                    page_map[page[pba_pkg::PAGE_W-1:pba_pkg::BIT_IDX_W]]
                            [page[pba_pkg::BIT_IDX_W-1:0]] = 1'b1;
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_in || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly low pages so the first-fit scan stays short; a few reach the whole range.
    function automatic logic [pba_pkg::PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return pba_pkg::PAGE_W'($urandom_range(0, 255));
        if (r < 92) return pba_pkg::PAGE_W'($urandom_range(0, 1023));
        return pba_pkg::PAGE_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return pba_pkg::MODE_ALLOC;
        if (r < 80) return pba_pkg::MODE_FREE;
        if (r < 97) return pba_pkg::MODE_RESERVE;
        return MODE_UNUSED;
    endfunction

    // Drives one request beat; valid stays high across back-to-back beats.
    task automatic issue(input logic [1:0] mode, input logic [pba_pkg::PAGE_W-1:0] page,
                         input logic typed, input t_grant want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_page_number <= page;
        req_notes.push_back('{typed, want});
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int k;
        int burst;
        int next_phase;
        foreach (page_map[w]) page_map[w] = pba_pkg::FULL_WORD;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            issue(DIRECTED[i].mode, DIRECTED[i].page, DIRECTED[i].typed,
                  '{DIRECTED[i].want_page, DIRECTED[i].want_found});

        n          = 0;
        next_phase = 0;
        while (n < RANDOM_ITEMS) begin
            if (n >= next_phase) begin
                quiet_in   = ($urandom_range(0, 3) == 0);
                next_phase = n + 150;
            end
            if ($urandom_range(0, 99) == 0) begin
                // run of allocates to drain the low pages and push the scan deeper
                burst = $urandom_range(8, 30);
                for (k = 0; k < burst; k++)
                    issue(pba_pkg::MODE_ALLOC, pba_pkg::PAGE_W'($urandom_range(0, 65535)),
                          1'b0, '0);
                n += burst;
            end else begin
                issue(pick_mode(), pick_page(), 1'b0, '0);
                n++;
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side back-pressure, with long stretches of ready held high.
    initial begin
        int r;
        int span;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                i_out_ready <= 1'b1;
                span = $urandom_range(100, 300);
            end else if (r < 60) begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end else begin
                i_out_ready <= 1'b0;
                span = pick_stall();
            end
            repeat (span) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_note  note;
        t_grant guess;
        t_grant want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                guess = predict_grant(i_mode, i_page_number);
                if (req_notes.size() == 0) begin
                    report_mismatch("request beat accepted that was never driven");
                end else begin
                    note = req_notes.pop_front();
                    expected_grants.push_back(note.typed ? note.want : guess);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("result beat page=%0d found=%0b with nothing pending",
                                              o_result_page, o_found));
                end else begin
                    want = expected_grants.pop_front();
                    if (o_result_page !== want.page)
                        report_mismatch($sformatf("result_page %0d, expected %0d",
                                                  o_result_page, want.page));
                    if (o_found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b", o_found, want.found));
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
